// ----- src/wsq_pkg.sv -----
// wsq_pkg: shared widths, verdict codes, register indexes and stage types
// for the wake swipe qualifier. Depends on nothing; used by every module.

package wsq_pkg;

  // field widths
  localparam int MoveWidth  = 13;
  localparam int MagWidth   = 13;
  localparam int NumWidth   = 16;
  localparam int QuoWidth   = 16;
  localparam int VelWidth   = 16;
  localparam int ZWidth     = 8;
  localparam int CfgWidth   = 17;
  localparam int IndexWidth = 3;

  // one divider cell per quotient bit
  localparam int NumCells = QuoWidth;

  // configuration register indexes
  localparam logic [IndexWidth-1:0] RegFingers     = 3'd0;
  localparam logic [IndexWidth-1:0] RegLarge       = 3'd1;
  localparam logic [IndexWidth-1:0] RegArea        = 3'd2;
  localparam logic [IndexWidth-1:0] RegSlant       = 3'd3;
  localparam logic [IndexWidth-1:0] RegSpeedFloor  = 3'd4;
  localparam logic [IndexWidth-1:0] RegSpeedCeil   = 3'd5;
  localparam logic [IndexWidth-1:0] RegStrFloor    = 3'd6;
  localparam logic [IndexWidth-1:0] RegStrCeil     = 3'd7;

  // verdict codes, first failing check wins
  typedef enum logic [3:0] {
    VERDICT_PASS      = 4'd0,
    VERDICT_FINGERS   = 4'd1,
    VERDICT_LARGE     = 4'd2,
    VERDICT_AREA      = 4'd3,
    VERDICT_DIRECTION = 4'd4,
    VERDICT_SLANT     = 4'd5,
    VERDICT_SLOW      = 4'd6,
    VERDICT_FAST      = 4'd7,
    VERDICT_WEAK      = 4'd8,
    VERDICT_STRONG    = 4'd9
  } verdict_t;

  // configuration registers, signed ones in two's complement
  typedef struct packed {
    logic [4:0]          required_fingers;
    logic                reject_large_object;
    logic [8:0]          area_limit;
    logic [CfgWidth-1:0] slant_limit;
    logic [CfgWidth-1:0] speed_floor;
    logic [CfgWidth-1:0] speed_ceiling;
    logic [8:0]          strength_floor;
    logic [8:0]          strength_ceiling;
  } cfg_t;

  // what travels alongside the division
  typedef struct packed {
    verdict_t            early;
    logic [VelWidth-1:0] velocity;
    logic [ZWidth-1:0]   strength;
  } meta_t;

  // one divider stage: remaining dividend bits, partial remainder, quotient, divisor and metadata
  typedef struct packed {
    logic [NumWidth-1:0] num;
    logic [MagWidth-1:0] rem;
    logic [QuoWidth-1:0] quo;
    logic [MagWidth-1:0] div;
    meta_t               meta;
  } stage_t;

endpackage

// ----- src/wsq_div_cell.sv -----
// wsq_div_cell: one restoring division cell, works out one quotient bit
// and hands the request on to the next cell. Depends on wsq_pkg.

module wsq_div_cell (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            up_valid,
  input  wsq_pkg::stage_t up_data,
  output logic            down_valid,
  output wsq_pkg::stage_t down_data
);

  logic [wsq_pkg::MagWidth:0] rem_shift;
  logic [wsq_pkg::MagWidth:0] div_ext;
  logic                       fits;
  logic [wsq_pkg::MagWidth:0] rem_sub;
  wsq_pkg::stage_t            stage_next;

  // bring down the next dividend bit and try the subtraction
  always_comb begin
    rem_shift  = {up_data.rem, up_data.num[wsq_pkg::NumWidth-1]};
    div_ext    = {1'b0, up_data.div};
    fits       = (rem_shift >= div_ext);
    rem_sub    = fits ? (rem_shift - div_ext) : rem_shift;
    stage_next = up_data;
    stage_next.num = {up_data.num[wsq_pkg::NumWidth-2:0], 1'b0};
    stage_next.rem = rem_sub[wsq_pkg::MagWidth-1:0];
    stage_next.quo = {up_data.quo[wsq_pkg::QuoWidth-2:0], fits};
  end

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      down_valid <= 1'b0;
    end else if (en) begin
      down_valid <= up_valid;
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (en) begin
      down_data <= stage_next;
    end
  end

endmodule

// ----- src/wsq_judge.sv -----
// wsq_judge: finishes the slant, speed and strength checks on the quotient
// from the last cell and holds the result register. Depends on wsq_pkg.

module wsq_judge (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            up_valid,
  input  wsq_pkg::stage_t up_data,
  input  wsq_pkg::cfg_t   cfg,
  output logic            result_valid,
  output logic            accepted,
  output logic [3:0]      verdict
);

  wsq_pkg::verdict_t verdict_next;
  logic              slant_fail;
  logic              slow_fail;
  logic              fast_fail;
  logic              weak_fail;
  logic              strong_fail;

  // late checks, a negative limit disables its check
  always_comb begin
    slant_fail  = !cfg.slant_limit[wsq_pkg::CfgWidth-1] &&
                  ({1'b0, up_data.quo} > cfg.slant_limit);
    slow_fail   = !cfg.speed_floor[wsq_pkg::CfgWidth-1] &&
                  ({1'b0, up_data.meta.velocity} < cfg.speed_floor);
    fast_fail   = !cfg.speed_ceiling[wsq_pkg::CfgWidth-1] &&
                  ({1'b0, up_data.meta.velocity} > cfg.speed_ceiling);
    weak_fail   = !cfg.strength_floor[8] &&
                  ({1'b0, up_data.meta.strength} <= cfg.strength_floor);
    strong_fail = !cfg.strength_ceiling[8] &&
                  ({1'b0, up_data.meta.strength} >= cfg.strength_ceiling);

    if (up_data.meta.early != wsq_pkg::VERDICT_PASS) begin
      verdict_next = up_data.meta.early;
    end else if (slant_fail) begin
      verdict_next = wsq_pkg::VERDICT_SLANT;
    end else if (slow_fail) begin
      verdict_next = wsq_pkg::VERDICT_SLOW;
    end else if (fast_fail) begin
      verdict_next = wsq_pkg::VERDICT_FAST;
    end else if (weak_fail) begin
      verdict_next = wsq_pkg::VERDICT_WEAK;
    end else if (strong_fail) begin
      verdict_next = wsq_pkg::VERDICT_STRONG;
    end else begin
      verdict_next = wsq_pkg::VERDICT_PASS;
    end
  end

  // result valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (en) begin
      result_valid <= up_valid;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (en) begin
      verdict  <= verdict_next;
      accepted <= (verdict_next == wsq_pkg::VERDICT_PASS);
    end
  end

endmodule

// ----- src/wake_swipe_qualifier_top.sv -----
// wake_swipe_qualifier_top: wake gesture qualifier, entry checks, a row of
// divider cells for the slant ratio and the final judge. Depends on
// wsq_pkg, wsq_div_cell and wsq_judge.
//
// Usage
//   A swipe summary is offered on swipe_valid/swipe_ready with its fields on
//   separate ports; one result (accepted, verdict) comes back per request on
//   result_valid/result_ready, in order. Verdict is the first failing check
//   or zero for a pass.
//   From acceptance to result_valid a request passes 16 divider cells, one
//   per quotient bit of |dx|*10/|dy|, and the result register. A new request
//   is taken every cycle while the row is not held, one swipe per cycle.
//   When result_ready is low with a result waiting, the whole row of cells
//   holds and swipe_ready drops; bubbles in the row are not squeezed out.
//   Reset clears every valid flag in the row and loads the registers with
//   their defaults (fingers 1, large reject on, area 75, slant 10, no speed
//   floor, speed ceiling 1000, strength 20 to 200).
//   Registers are written through cfg_we/cfg_index/cfg_wdata, one per
//   cycle, and should only change while no request is in flight.

module wake_swipe_qualifier_top (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             swipe_valid,
  output logic                             swipe_ready,
  input  logic [wsq_pkg::MoveWidth-1:0]    move_x,
  input  logic [wsq_pkg::MoveWidth-1:0]    move_y,
  input  logic [3:0]                       contact_width,
  input  logic [3:0]                       contact_height,
  input  logic [wsq_pkg::VelWidth-1:0]     velocity,
  input  logic [wsq_pkg::ZWidth-1:0]       strength,
  input  logic [3:0]                       finger_count,
  input  logic                             big_object,
  output logic                             result_valid,
  input  logic                             result_ready,
  output logic                             accepted,
  output logic [3:0]                       verdict,
  input  logic                             cfg_we,
  input  logic [wsq_pkg::IndexWidth-1:0]   cfg_index,
  input  logic [wsq_pkg::CfgWidth-1:0]     cfg_wdata
);

  wsq_pkg::cfg_t                cfg;
  logic                         en;
  logic [7:0]                   area;
  logic [wsq_pkg::MagWidth-1:0] abs_x;
  logic [wsq_pkg::MagWidth-1:0] abs_y;
  logic [wsq_pkg::NumWidth-1:0] abs_x_ext;
  wsq_pkg::verdict_t            early;
  wsq_pkg::stage_t              head_data;
  wsq_pkg::stage_t              chain_data  [0:wsq_pkg::NumCells];
  logic [wsq_pkg::NumCells:0]   chain_valid;

  // the whole row moves unless a result is waiting and result_ready is low
  assign en          = !result_valid || result_ready;
  assign swipe_ready = en;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.required_fingers    <= 5'd1;
      cfg.reject_large_object <= 1'b1;
      cfg.area_limit          <= 9'd75;
      cfg.slant_limit         <= 17'd10;
      cfg.speed_floor         <= '1;
      cfg.speed_ceiling       <= 17'd1000;
      cfg.strength_floor      <= 9'd20;
      cfg.strength_ceiling    <= 9'd200;
    end else if (cfg_we) begin
      unique case (cfg_index)
        wsq_pkg::RegFingers:    cfg.required_fingers    <= cfg_wdata[4:0];
        wsq_pkg::RegLarge:      cfg.reject_large_object <= cfg_wdata[0];
        wsq_pkg::RegArea:       cfg.area_limit          <= cfg_wdata[8:0];
        wsq_pkg::RegSlant:      cfg.slant_limit         <= cfg_wdata;
        wsq_pkg::RegSpeedFloor: cfg.speed_floor         <= cfg_wdata;
        wsq_pkg::RegSpeedCeil:  cfg.speed_ceiling       <= cfg_wdata;
        wsq_pkg::RegStrFloor:   cfg.strength_floor      <= cfg_wdata[8:0];
        wsq_pkg::RegStrCeil:    cfg.strength_ceiling    <= cfg_wdata[8:0];
        default: ;
      endcase
    end
  end

  // contact area, |dx| and |dy|, the latter valid only for a negative move_y
  always_comb begin
    area      = contact_width * contact_height;
    abs_x     = move_x[wsq_pkg::MoveWidth-1] ? (~move_x + 1'b1) : move_x;
    abs_y     = ~move_y + 1'b1;
    abs_x_ext = {{(wsq_pkg::NumWidth-wsq_pkg::MagWidth){1'b0}}, abs_x};
  end

  // entry checks in priority order
  always_comb begin
    if (!cfg.required_fingers[4] && ({1'b0, finger_count} != cfg.required_fingers)) begin
      early = wsq_pkg::VERDICT_FINGERS;
    end else if (cfg.reject_large_object && big_object) begin
      early = wsq_pkg::VERDICT_LARGE;
    end else if (!cfg.area_limit[8] && ({1'b0, area} > cfg.area_limit)) begin
      early = wsq_pkg::VERDICT_AREA;
    end else if (!move_y[wsq_pkg::MoveWidth-1]) begin
      early = wsq_pkg::VERDICT_DIRECTION;
    end else begin
      early = wsq_pkg::VERDICT_PASS;
    end
  end

  // request into the first cell
  always_comb begin
    head_data.num           = (abs_x_ext << 3) + (abs_x_ext << 1);
    head_data.rem           = '0;
    head_data.quo           = '0;
    head_data.div           = abs_y;
    head_data.meta.early    = early;
    head_data.meta.velocity = velocity;
    head_data.meta.strength = strength;
  end

  assign chain_valid[0] = swipe_valid;
  assign chain_data[0]  = head_data;

  // row of divider cells
  for (genvar i = 0; i < wsq_pkg::NumCells; i++) begin : g_cell
    wsq_div_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .en         (en),
      .up_valid   (chain_valid[i]),
      .up_data    (chain_data[i]),
      .down_valid (chain_valid[i+1]),
      .down_data  (chain_data[i+1])
    );
  end

  // late checks and result register
  wsq_judge u_judge (
    .clk          (clk),
    .rst          (rst),
    .en           (en),
    .up_valid     (chain_valid[wsq_pkg::NumCells]),
    .up_data      (chain_data[wsq_pkg::NumCells]),
    .cfg          (cfg),
    .result_valid (result_valid),
    .accepted     (accepted),
    .verdict      (verdict)
  );

endmodule
